### design/cso_pkg.sv
// Shared constants, parameter defaults and glyph tables for the cursor overlay writer.
package cso_pkg;

  localparam int PANEL_WIDTH_DEF = 320;
  localparam int ACTIVE_ROWS_DEF = 200;
  localparam int TOP_MARGIN_DEF  = 20;

  localparam int EXTENT_W = 16;

  localparam logic [3:0] COLOR_BODY    = 4'd15;
  localparam logic [3:0] COLOR_OUTLINE = 4'd0;

  localparam logic REG_RENDER_ENABLE = 1'b0;
  localparam logic RENDER_ENABLE_RST = 1'b1;

  function automatic logic [7:0] glyph_body(input logic [2:0] r);
    logic [7:0] bits;
    unique case (r)
      3'd0: bits = 8'h80;
      3'd1: bits = 8'hC0;
      3'd2: bits = 8'hE0;
      3'd3: bits = 8'hF0;
      3'd4: bits = 8'hF8;
      3'd5: bits = 8'hE0;
      3'd6: bits = 8'h90;
      3'd7: bits = 8'h10;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

  // Pixels that are clear but touch the body horizontally or vertically.
  function automatic logic [7:0] glyph_outline(input logic [2:0] r);
    logic [7:0] row;
    logic [7:0] up;
    logic [7:0] down;
    row  = glyph_body(r);
    up   = (r != 3'd0) ? glyph_body(r - 3'd1) : 8'h00;
    down = (r != 3'd7) ? glyph_body(r + 3'd1) : 8'h00;
    return ((row << 1) | (row >> 1) | up | down) & ~row;
  endfunction

endpackage

### design/cso_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by both axes.
module cso_div #(
  parameter int N = 27
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [15:0]  divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N);

  logic          busy;
  logic [CW-1:0] count;
  logic [15:0]   rem;
  logic [15:0]   dvs;
  logic [N-1:0]  quo;
  logic [16:0]   shifted;
  logic [16:0]   diff;
  logic          fits;

  always_comb begin
    shifted = {rem, quo[N-1]};
    fits    = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        dvs   <= divisor;
        quo   <= dividend;
      end else if (busy) begin
        rem   <= fits ? diff[15:0] : shifted[15:0];
        quo   <= {quo[N-2:0], fits};
        count <= count + 1'b1;
        if (count == CW'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a run");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

### design/cursor_sprite_overlay_writer_core.sv
// Top level of the cursor overlay writer: sequencer, pixel walk and output stage.
//
//  port group   dir   beat contents
//  s_*          in    one frame request: pointer, hotspot, virtual extent, wanted flag
//  m_*          out   one framebuffer write: address, color, last of frame
//  APB          in    render_enable register at byte address 0
//
// A shown frame keeps s_tready low while the bit-serial divider runs once per axis and
// the 64-cell glyph walk and flush finish, plus any output stalls. A suppressed frame is
// accepted in idle and the block stays idle. Reset clears the control state and sets
// render_enable. A stalled m_ side holds the walk once a second write is waiting;
// s_tready stays low for the whole frame.
module cursor_sprite_overlay_writer_core #(
  parameter int PANEL_WIDTH = cso_pkg::PANEL_WIDTH_DEF,
  parameter int ACTIVE_ROWS = cso_pkg::ACTIVE_ROWS_DEF,
  parameter int TOP_MARGIN  = cso_pkg::TOP_MARGIN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] pointer_x, [31:16] pointer_y, [47:32] hot_x, [63:48] hot_y,
  // [79:64] extent_w, [95:80] extent_h
  input  logic [95:0] s_tdata,
  // [0] cursor_wanted
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [16:0] pixel_addr, [20:17] pixel_color, [23:21] zero
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cso_pkg::*;

  localparam int SCALE_MAX = (PANEL_WIDTH > ACTIVE_ROWS) ? PANEL_WIDTH : ACTIVE_ROWS;
  localparam int SCALE_W   = $clog2(SCALE_MAX + 1);
  localparam int N         = EXTENT_W + SCALE_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MULX  = 8'b0000_0010,
    ST_DIVX  = 8'b0000_0100,
    ST_MULY  = 8'b0000_1000,
    ST_DIVY  = 8'b0001_0000,
    ST_BASE  = 8'b0010_0000,
    ST_WALK  = 8'b0100_0000,
    ST_FLUSH = 8'b1000_0000
  } state_t;

  state_t state;

  logic                render_enable;
  logic signed [16:0]  dx;
  logic signed [16:0]  dy;
  logic [15:0]         ew;
  logic [15:0]         eh;
  logic signed [N:0]   px;
  logic signed [N+1:0] py;
  logic [16:0]         rowbase;
  logic [2:0]          row;
  logic [2:0]          col;

  logic                pend_valid;
  logic [16:0]         pend_addr;
  logic [3:0]          pend_color;
  logic [16:0]         out_addr;
  logic [3:0]          out_color;
  logic                out_last;

  logic                cfg_write;
  logic                accept;
  logic                shown;
  logic [16:0]         dx_next;
  logic [16:0]         dy_next;

  logic                sel_y;
  logic [16:0]         d_sel;
  logic                neg;
  logic [16:0]         mag;
  logic [SCALE_W-1:0]  scale;
  logic [N-1:0]        dividend;
  logic [15:0]         divisor;
  logic                div_start;
  logic                div_done;
  logic [N-1:0]        quotient;
  logic [N:0]          sq;

  logic [N+1:0]        xw;
  logic [N+2:0]        yw;
  logic                x_ok;
  logic                y_ok;
  logic [7:0]          body_row;
  logic [7:0]          outline_row;
  logic                body_bit;
  logic                outline_bit;
  logic                hit;
  logic                out_free;
  logic                walk_stall;
  logic                out_load;
  logic [16:0]         cell_addr;

  cso_div #(.N(N)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    cfg_write = psel && penable && pwrite && pready;
    accept    = s_tvalid && s_tready;
    shown     = render_enable && s_tuser && (s_tdata[79:64] != 16'd0) &&
                (s_tdata[95:80] != 16'd0);
    dx_next   = {s_tdata[15], s_tdata[15:0]} - {s_tdata[47], s_tdata[47:32]};
    dy_next   = {s_tdata[31], s_tdata[31:16]} - {s_tdata[63], s_tdata[63:48]};

    sel_y     = (state == ST_MULY) || (state == ST_DIVY);
    d_sel     = sel_y ? dy : dx;
    neg       = d_sel[16];
    mag       = neg ? (~d_sel + 17'd1) : d_sel;
    scale     = sel_y ? SCALE_W'(ACTIVE_ROWS) : SCALE_W'(PANEL_WIDTH);
    dividend  = N'(mag[15:0] * scale);
    divisor   = sel_y ? eh : ew;
    div_start = (state == ST_MULX) || (state == ST_MULY);
    sq        = neg ? ((N+1)'(0) - {1'b0, quotient}) : {1'b0, quotient};

    xw          = {px[N], px} + (N+2)'(col);
    yw          = {py[N+1], py} + (N+3)'(row);
    x_ok        = !xw[N+1] && (xw < (N+2)'(PANEL_WIDTH));
    y_ok        = !yw[N+2] && (yw >= (N+3)'(TOP_MARGIN)) &&
                  (yw < (N+3)'(TOP_MARGIN + ACTIVE_ROWS));
    body_row    = glyph_body(row);
    outline_row = glyph_outline(row);
    body_bit    = body_row[3'd7 - col];
    outline_bit = outline_row[3'd7 - col];
    hit         = x_ok && y_ok && (body_bit || outline_bit);
    out_free    = !m_tvalid || m_tready;
    walk_stall  = hit && pend_valid && !out_free;
    out_load    = ((state == ST_WALK) && !walk_stall && hit && pend_valid) ||
                  ((state == ST_FLUSH) && pend_valid && out_free);
    cell_addr   = rowbase + xw[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      render_enable <= RENDER_ENABLE_RST;
    end else if (cfg_write && (paddr[2] == REG_RENDER_ENABLE)) begin
      render_enable <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && shown) begin
            dx    <= $signed(dx_next);
            dy    <= $signed(dy_next);
            ew    <= s_tdata[79:64];
            eh    <= s_tdata[95:80];
            state <= ST_MULX;
          end
        end
        ST_MULX: state <= ST_DIVX;
        ST_DIVX: begin
          if (div_done) begin
            px    <= $signed(sq);
            state <= ST_MULY;
          end
        end
        ST_MULY: state <= ST_DIVY;
        ST_DIVY: begin
          if (div_done) begin
            py    <= $signed({sq[N], sq}) + (N+2)'(TOP_MARGIN);
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          rowbase <= 17'(py[16:0] * 17'(PANEL_WIDTH));
          row     <= 3'd0;
          col     <= 3'd0;
          state   <= ST_WALK;
        end
        ST_WALK: begin
          if (!walk_stall) begin
            if (hit) begin
              pend_valid <= 1'b1;
              pend_addr  <= cell_addr;
              pend_color <= body_bit ? COLOR_BODY : COLOR_OUTLINE;
              if (pend_valid) begin
                out_addr  <= pend_addr;
                out_color <= pend_color;
                out_last  <= 1'b0;
              end
            end
            col <= col + 3'd1;
            if (col == 3'd7) begin
              row     <= row + 3'd1;
              rowbase <= rowbase + 17'(PANEL_WIDTH);
              if (row == 3'd7) begin
                state <= ST_FLUSH;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_addr   <= pend_addr;
            out_color  <= pend_color;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {3'b000, out_color, out_addr};
  assign m_tlast  = out_last;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_RENDER_ENABLE) ? {31'd0, render_enable} : 32'd0;

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
      div_done |-> (state == ST_DIVX || state == ST_DIVY))
    else $error("divider finished outside a divide state");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
      s_tready |-> !pend_valid)
    else $error("pending write left over when idle");
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
      (state == ST_BASE) |=> (state == ST_WALK && row == 3'd0 && col == 3'd0))
    else $error("walk did not start at the first cell");

endmodule
